FILE: rtl/cell_fluid_fraction_from_plane_core_macros.svh
// Assertion macros for the top level of the cell fluid fraction RTL
`ifndef CELL_FLUID_FRACTION_FROM_PLANE_CORE_MACROS_SVH
`define CELL_FLUID_FRACTION_FROM_PLANE_CORE_MACROS_SVH

// Check a condition in the same cycle as its trigger
`define CFFP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a condition in the cycle after its trigger
`define CFFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/cffp_pkg.sv
// Types and constants shared by the cell fluid fraction pipeline
`timescale 1ns / 1ps
package cffp_pkg;

  localparam int unsigned NUM_W = 64;   // signed numerator width
  localparam int unsigned DEN_W = 57;   // denominator width, 48*abc < 2^57

  typedef enum logic [1:0] {
    FORCE_NONE,
    FORCE_ZERO,
    FORCE_ONE,
    FORCE_HALF
  } force_t;

  typedef enum logic [1:0] {
    REG_LO,
    REG_HI,
    REG_MID
  } region_t;

  // Operands after classification
  typedef struct packed {
    force_t          frc;
    logic            cube;
    region_t         rgn;
    logic [19:0]     t;
    logic [19:0]     lin_n;
    logic [18:0]     lin_d;
    logic [17:0]     p;
    logic [17:0]     q;
    logic [17:0]     a;
    logic [17:0]     b;
    logic [17:0]     c;
    logic [7:0][19:0] v;
  } prep_t;

  // Ratio handed to the divider
  typedef struct packed {
    force_t                   frc;
    logic signed [NUM_W-1:0]  num;
    logic [DEN_W-1:0]         den;
  } ratio_t;

endpackage

FILE: rtl/cffp_prep.sv
// Front stages: absolute values, component selection and case classification
`timescale 1ns / 1ps
module cffp_prep
  import cffp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic               three_d_mode,
  input  logic [17:0]        nx,
  input  logic [17:0]        ny,
  input  logic [17:0]        nz,
  input  logic [18:0]        offs,
  output logic               out_valid,
  output prep_t              out_data
);

  logic               vld_a_r;
  logic [17:0]        a_r, b_r, c_r, p_r, q_r;
  logic signed [19:0] d2_r;
  logic               cube_r, allz_r;
  logic [17:0]        a_nxt, b_nxt, c_nxt, p_nxt, q_nxt;

  logic               vld_b_r;
  prep_t              prep_r, prep_nxt;

  logic signed [21:0] as_s, bs_s, cs_s, ps_s, qs_s, ds_s;
  logic signed [21:0] n1_s, mn_s, mx_s, l1_s, t_s, lin_s;
  logic signed [21:0] va [8];

  // Take magnitude and pick the pair used by the planar formula
  always_comb begin
    a_nxt = nx[17] ? (~nx + 18'd1) : nx;
    b_nxt = ny[17] ? (~ny + 18'd1) : ny;
    c_nxt = nz[17] ? (~nz + 18'd1) : nz;
    p_nxt = a_nxt;
    q_nxt = b_nxt;
    if (three_d_mode) begin
      if (a_nxt == '0) begin
        p_nxt = b_nxt;
        q_nxt = c_nxt;
      end else if (b_nxt == '0) begin
        q_nxt = c_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else if (en) begin
      vld_a_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r    <= a_nxt;
      b_r    <= b_nxt;
      c_r    <= c_nxt;
      p_r    <= p_nxt;
      q_r    <= q_nxt;
      d2_r   <= $signed({offs, 1'b0});
      cube_r <= three_d_mode && (a_nxt != '0) && (b_nxt != '0) && (c_nxt != '0);
      allz_r <= three_d_mode && (a_nxt == '0) && (b_nxt == '0) && (c_nxt == '0);
    end
  end

  // Classify the item and form the corner distances of the cube
  always_comb begin
    as_s = $signed({4'b0, a_r});
    bs_s = $signed({4'b0, b_r});
    cs_s = $signed({4'b0, c_r});
    ps_s = $signed({4'b0, p_r});
    qs_s = $signed({4'b0, q_r});
    ds_s = $signed({{2{d2_r[19]}}, d2_r});

    va[0] = ds_s + as_s + bs_s + cs_s;
    va[1] = ds_s - as_s + bs_s + cs_s;
    va[2] = ds_s + as_s - bs_s + cs_s;
    va[3] = ds_s + as_s + bs_s - cs_s;
    va[4] = ds_s - as_s - bs_s + cs_s;
    va[5] = ds_s - as_s + bs_s - cs_s;
    va[6] = ds_s + as_s - bs_s - cs_s;
    va[7] = ds_s - as_s - bs_s - cs_s;
    l1_s  = as_s + bs_s + cs_s;

    n1_s = ps_s + qs_s;
    mn_s = (ps_s < qs_s) ? ps_s : qs_s;
    mx_s = (ps_s < qs_s) ? qs_s : ps_s;

    prep_nxt      = '0;
    prep_nxt.cube = cube_r;
    prep_nxt.p    = p_r;
    prep_nxt.q    = q_r;
    prep_nxt.a    = a_r;
    prep_nxt.b    = b_r;
    prep_nxt.c    = c_r;
    for (int i = 0; i < 8; i++) begin
      prep_nxt.v[i] = (va[i] > 22'sd0) ? va[i][19:0] : 20'd0;
    end

    // Clamp outside the cell
    if (allz_r) begin
      if (ds_s < 22'sd0) begin
        prep_nxt.frc = FORCE_ZERO;
      end else if (ds_s > 22'sd0) begin
        prep_nxt.frc = FORCE_ONE;
      end else begin
        prep_nxt.frc = FORCE_HALF;
      end
    end else if (cube_r) begin
      if (va[0] <= 22'sd0) begin
        prep_nxt.frc = FORCE_ZERO;
      end else if (va[0] >= (l1_s <<< 1)) begin
        prep_nxt.frc = FORCE_ONE;
      end else begin
        prep_nxt.frc = FORCE_NONE;
      end
    end else begin
      if (ds_s <= -n1_s) begin
        prep_nxt.frc = FORCE_ZERO;
      end else if (ds_s >= n1_s) begin
        prep_nxt.frc = FORCE_ONE;
      end else begin
        prep_nxt.frc = FORCE_NONE;
      end
    end

    // Pick the planar piece: corner triangle, corner cut, or trapezoid
    if (ds_s < mn_s - mx_s) begin
      prep_nxt.rgn = REG_LO;
      t_s = ds_s + n1_s;
    end else if (ds_s > mx_s - mn_s) begin
      prep_nxt.rgn = REG_HI;
      t_s = n1_s - ds_s;
    end else begin
      prep_nxt.rgn = REG_MID;
      t_s = n1_s - ds_s;
    end
    lin_s          = mx_s + ds_s;
    prep_nxt.t     = t_s[19:0];
    prep_nxt.lin_n = lin_s[19:0];
    prep_nxt.lin_d = {mx_s[17:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_b_r <= 1'b0;
    end else if (en) begin
      vld_b_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prep_r <= prep_nxt;
    end
  end

  assign out_valid = vld_b_r;
  assign out_data  = prep_r;

endmodule

FILE: rtl/cffp_prod.sv
// Product stages: squares, cubes and the numerator and denominator of the ratio
`timescale 1ns / 1ps
module cffp_prod
  import cffp_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  logic   in_valid,
  input  prep_t  in_data,
  output logic   out_valid,
  output ratio_t out_data
);

  // Stage C
  logic                    vld_c_r;
  logic [39:0]             sq_r [8];
  logic [19:0]             v_c_r [8];
  logic [39:0]             tt_r;
  logic [35:0]             ab_r, pq_r;
  logic [17:0]             c_c_r;
  force_t                  frc_c_r;
  logic                    cube_c_r;
  region_t                 rgn_c_r;
  logic [19:0]             lin_n_c_r;
  logic [18:0]             lin_d_c_r;

  // Stage D
  logic                    vld_d_r;
  logic [39:0]             cpl_r [8];
  logic [39:0]             cph_r [8];
  logic [35:0]             abcl_r, abch_r;
  logic signed [NUM_W-1:0] num2_d_r, num2_nxt;
  logic [DEN_W-1:0]        den2_d_r, den2_nxt;
  logic [38:0]             pq8;
  force_t                  frc_d_r;
  logic                    cube_d_r;

  // Stage E
  logic                    vld_e_r;
  logic [59:0]             cb_r [8];
  logic [53:0]             abc_r;
  logic signed [NUM_W-1:0] num2_e_r;
  logic [DEN_W-1:0]        den2_e_r;
  force_t                  frc_e_r;
  logic                    cube_e_r;

  // Stage F
  logic                    vld_f_r;
  logic signed [NUM_W-1:0] sa_r, sb_r;
  logic signed [NUM_W-1:0] cs [8];
  logic [DEN_W-1:0]        d48_r;
  logic signed [NUM_W-1:0] num2_f_r;
  logic [DEN_W-1:0]        den2_f_r;
  force_t                  frc_f_r;
  logic                    cube_f_r;

  // Stage G
  logic                    vld_g_r;
  ratio_t                  ratio_r, ratio_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_c_r <= 1'b0;
      vld_d_r <= 1'b0;
      vld_e_r <= 1'b0;
      vld_f_r <= 1'b0;
      vld_g_r <= 1'b0;
    end else if (en) begin
      vld_c_r <= in_valid;
      vld_d_r <= vld_c_r;
      vld_e_r <= vld_d_r;
      vld_f_r <= vld_e_r;
      vld_g_r <= vld_f_r;
    end
  end

  // Square the corner distances and form the pair products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 8; i++) begin
        sq_r[i]  <= in_data.v[i] * in_data.v[i];
        v_c_r[i] <= in_data.v[i];
      end
      tt_r      <= in_data.t * in_data.t;
      ab_r      <= in_data.a * in_data.b;
      pq_r      <= in_data.p * in_data.q;
      c_c_r     <= in_data.c;
      frc_c_r   <= in_data.frc;
      cube_c_r  <= in_data.cube;
      rgn_c_r   <= in_data.rgn;
      lin_n_c_r <= in_data.lin_n;
      lin_d_c_r <= in_data.lin_d;
    end
  end

  // Select the planar numerator and denominator
  always_comb begin
    pq8 = {pq_r, 3'b0};
    case (rgn_c_r)
      REG_LO: begin
        num2_nxt = $signed({24'b0, tt_r});
        den2_nxt = DEN_W'(pq8);
      end
      REG_HI: begin
        num2_nxt = $signed({25'b0, pq8}) - $signed({24'b0, tt_r});
        den2_nxt = DEN_W'(pq8);
      end
      default: begin
        num2_nxt = $signed({44'b0, lin_n_c_r});
        den2_nxt = DEN_W'(lin_d_c_r);
      end
    endcase
  end

  // Split the cube and triple products into narrow partial products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 8; i++) begin
        cpl_r[i] <= sq_r[i][19:0] * v_c_r[i];
        cph_r[i] <= sq_r[i][39:20] * v_c_r[i];
      end
      abcl_r   <= ab_r[17:0] * c_c_r;
      abch_r   <= ab_r[35:18] * c_c_r;
      num2_d_r <= num2_nxt;
      den2_d_r <= den2_nxt;
      frc_d_r  <= frc_c_r;
      cube_d_r <= cube_c_r;
    end
  end

  // Merge partial products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 8; i++) begin
        cb_r[i] <= {20'b0, cpl_r[i]} + {cph_r[i], 20'b0};
      end
      abc_r    <= {18'b0, abcl_r} + {abch_r, 18'b0};
      num2_e_r <= num2_d_r;
      den2_e_r <= den2_d_r;
      frc_e_r  <= frc_d_r;
      cube_e_r <= cube_d_r;
    end
  end

  // Inclusion-exclusion in two half sums
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      cs[i] = $signed({4'b0, cb_r[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa_r     <= cs[0] - cs[1] - cs[2] - cs[3];
      sb_r     <= cs[4] + cs[5] + cs[6] - cs[7];
      d48_r    <= DEN_W'({abc_r, 5'b0}) + DEN_W'({abc_r, 4'b0});
      num2_f_r <= num2_e_r;
      den2_f_r <= den2_e_r;
      frc_f_r  <= frc_e_r;
      cube_f_r <= cube_e_r;
    end
  end

  // Pick the cube or planar ratio
  always_comb begin
    ratio_nxt.frc = frc_f_r;
    ratio_nxt.num = cube_f_r ? (sa_r + sb_r) : num2_f_r;
    ratio_nxt.den = cube_f_r ? d48_r : den2_f_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ratio_r <= ratio_nxt;
    end
  end

  assign out_valid = vld_g_r;
  assign out_data  = ratio_r;

endmodule

FILE: rtl/cffp_div.sv
// Pipelined restoring divider with round-to-nearest of the fraction
`timescale 1ns / 1ps
module cffp_div
  import cffp_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  ratio_t               in_data,
  output logic                 out_valid,
  output logic [FRAC_BITS:0]   out_frac
);

  localparam int unsigned QW = FRAC_BITS + 1;

  logic               vld_r [QW+1];
  logic [DEN_W-1:0]   rem_r [QW+1];
  logic [DEN_W-1:0]   den_r [QW+1];
  logic [QW-1:0]      quo_r [QW+1];
  force_t             frc_r [QW+1];
  force_t             frc_nxt;
  logic [QW:0]        quo_inc;

  // Resolve the trivial ratios before dividing
  always_comb begin
    if (in_data.frc != FORCE_NONE) begin
      frc_nxt = in_data.frc;
    end else if (in_data.num <= $signed(NUM_W'(0)) || in_data.den == '0) begin
      frc_nxt = FORCE_ZERO;
    end else if (in_data.num >= $signed({{(NUM_W-DEN_W){1'b0}}, in_data.den})) begin
      frc_nxt = FORCE_ONE;
    end else begin
      frc_nxt = FORCE_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= in_data.num[DEN_W-1:0];
      den_r[0] <= in_data.den;
      quo_r[0] <= '0;
      frc_r[0] <= frc_nxt;
    end
  end

  // One quotient bit per stage
  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DEN_W:0]   shl;
    logic             ge;
    logic [DEN_W:0]   dif;
    logic [DEN_W-1:0] rem_nxt;
    logic [QW-1:0]    quo_nxt;

    always_comb begin
      shl     = {rem_r[k], 1'b0};
      dif     = shl - {1'b0, den_r[k]};
      ge      = shl >= {1'b0, den_r[k]};
      rem_nxt = ge ? dif[DEN_W-1:0] : shl[DEN_W-1:0];
      quo_nxt = {quo_r[k][QW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= rem_nxt;
        den_r[k+1] <= den_r[k];
        quo_r[k+1] <= quo_nxt;
        frc_r[k+1] <= frc_r[k];
      end
    end
  end

  // Round half up and apply forced results
  always_comb begin
    quo_inc = {1'b0, quo_r[QW]} + {{QW{1'b0}}, 1'b1};
    unique case (frc_r[QW])
      FORCE_ZERO: out_frac = '0;
      FORCE_ONE:  out_frac = QW'(1) << FRAC_BITS;
      FORCE_HALF: out_frac = QW'(1) << (FRAC_BITS - 1);
      default:    out_frac = quo_inc[QW:1];
    endcase
  end

  assign out_valid = vld_r[QW];

endmodule

FILE: rtl/cell_fluid_fraction_from_plane_core.sv
// Top level of the cell fluid fraction pipeline
//
//   channel  dir  fields (lowest bit first)
//   in_      in   normal_x[17:0] normal_y[35:18] normal_z[53:36] offset[72:54]
//   out_     out  fraction[FRAC_BITS:0]
//   cfg_     in   three_d_mode (single register, write only)
//
// One item per cycle while the output is not stalled; the pipeline depth is set mostly
// by the restoring divider with FRAC_BITS + 1 one-bit stages.
// rst_n is synchronous and active low; the mode register resets to 3D.
// A stalled output parks one result in a skid register and freezes the pipeline;
// in_tready is registered and drops only while the skid register is full.
`timescale 1ns / 1ps
`include "cell_fluid_fraction_from_plane_core_macros.svh"
module cell_fluid_fraction_from_plane_core
  import cffp_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [79:0]         in_tdata,   // normal_x, normal_y, normal_z, offset
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [((FRAC_BITS+8)/8)*8-1:0] out_tdata, // fraction
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data
);

  localparam int unsigned OW    = FRAC_BITS + 1;
  localparam int unsigned OUT_W = ((FRAC_BITS + 8) / 8) * 8;

  logic          three_d_mode_r;
  logic          en;
  logic          prep_vld, prod_vld, div_vld;
  prep_t         prep_data;
  ratio_t        ratio_data;
  logic [OW-1:0] div_frac;
  logic          push;

  logic          out_valid_r, skid_valid_r;
  logic [OW-1:0] out_frac_r, skid_frac_r;

  // Mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      three_d_mode_r <= 1'b1;
    end else if (cfg_wr_en) begin
      three_d_mode_r <= cfg_wr_data;
    end
  end

  assign en   = !skid_valid_r;
  assign push = en && div_vld;

  cffp_prep u_prep (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (in_tvalid),
    .three_d_mode (three_d_mode_r),
    .nx           (in_tdata[17:0]),
    .ny           (in_tdata[35:18]),
    .nz           (in_tdata[53:36]),
    .offs         (in_tdata[72:54]),
    .out_valid    (prep_vld),
    .out_data     (prep_data)
  );

  cffp_prod u_prod (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (prep_vld),
    .in_data   (prep_data),
    .out_valid (prod_vld),
    .out_data  (ratio_data)
  );

  cffp_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (prod_vld),
    .in_data   (ratio_data),
    .out_valid (div_vld),
    .out_frac  (div_frac)
  );

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_tready || !out_valid_r) begin
      out_valid_r  <= skid_valid_r || push;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_tready || !out_valid_r) begin
      out_frac_r <= skid_valid_r ? skid_frac_r : div_frac;
    end else if (push) begin
      skid_frac_r <= div_frac;
    end
  end

  assign in_tready  = en;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_frac_r);

  `CFFP_ASSERT_SAME(a_skid_needs_out, skid_valid_r, out_valid_r, "skid full with empty output")
  `CFFP_ASSERT_SAME(a_frac_range, out_valid_r, out_frac_r <= (OW'(1) << FRAC_BITS), "fraction above one")
  `CFFP_ASSERT_NEXT(a_skid_drain, skid_valid_r && out_tready, !skid_valid_r, "skid not drained")

endmodule
